// ----- rtl/abd_pkg.sv -----
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types and constants of the anchor box decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int MAX_ANCHORS_DEF = 16384;

    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_CLASS_COUNT     = 3'd1;
    localparam logic [2:0] REG_PAD_LEFT        = 3'd2;
    localparam logic [2:0] REG_PAD_TOP         = 3'd3;
    localparam logic [2:0] REG_INVERSE_GAIN    = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd6;

    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [7:0]  RST_CLASS_COUNT     = 8'd80;
    localparam logic [15:0] RST_PAD_LEFT        = 16'd0;
    localparam logic [15:0] RST_PAD_TOP         = 16'd0;
    localparam logic [15:0] RST_INVERSE_GAIN    = 16'd4096;
    localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd640;

    localparam logic [12:0] IMAGE_MAX = 13'd4096;
    localparam logic [7:0]  CLASS_NONE = 8'hFF;

    typedef struct packed {
        logic [15:0] pad_left;
        logic [15:0] pad_top;
        logic [15:0] inverse_gain;
        logic [12:0] w_lim;
        logic [12:0] h_lim;
    } box_cfg_t;

    typedef struct packed {
        logic [15:0]        best_score;
        logic signed [7:0]  best_class;
        logic [13:0]        anchor_index;
    } meta_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        meta_t       meta;
    } box_item_t;

    typedef struct packed {
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [12:0] box_width;
        logic [12:0] box_height;
        meta_t       meta;
    } box_result_t;

endpackage

// ----- rtl/anchor_box_decode_argmax.sv -----
// ----------------------------------------------------------------------------
// anchor_box_decode_argmax
// Anchor box decoder: running class argmax, threshold, letterbox removal
// and scaling of each kept anchor.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                           Word contents (low bit up)
// s        in   s_tvalid s_tready s_tdata s_tuser feature_value; frame_start
// m        out  m_tvalid m_tready m_tdata         box fields, score, class, index
// apb      in   psel penable pwrite paddr pwdata  seven configuration registers
//
// One input word per cycle while s_tready is high; the argmax updates at the accepting edge.
// A kept anchor's result passes the hand-off register and three arithmetic stages.
// s_tready falls only when the hand-off register and all three arithmetic
// stages are full and m_tready is low.
// Reset clears counters, valids and the argmax and loads register defaults.
// ----------------------------------------------------------------------------
module anchor_box_decode_argmax
#(
    parameter int MAX_CLASSES = abd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_ANCHORS = abd_pkg::MAX_ANCHORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // feature_value
    input  logic [0:0]  s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // box_left, box_top, box_width, box_height, best_score, best_class,
    // anchor_index
    output logic [87:0] m_tdata
);

    localparam int ANCHOR_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam logic [ANCHOR_W-1:0] ANCHOR_LAST = ANCHOR_W'(MAX_ANCHORS - 1);
    localparam logic [ANCHOR_W-1:0] ANCHOR_ONE  = ANCHOR_W'(1);
    localparam logic [7:0] CLASS_LIMIT = 8'(MAX_CLASSES);

    logic [15:0] score_threshold_reg;
    logic [7:0]  class_count_reg;
    logic [15:0] pad_left_reg;
    logic [15:0] pad_top_reg;
    logic [15:0] inverse_gain_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic        cfg_write;

    logic [7:0]          pos_reg, pos_next;
    logic [ANCHOR_W-1:0] anchor_reg, anchor_next;
    logic [15:0]         box_reg [4];
    logic [15:0]         best_score_reg, best_score_next;
    logic [7:0]          best_class_reg, best_class_next;

    logic                a_valid_reg, a_valid_next;
    abd_pkg::box_item_t  a_item_reg;
    logic                a_take;

    logic [7:0]          eff_pos;
    logic [ANCHOR_W-1:0] eff_anchor;
    logic [15:0]         eff_score;
    logic [7:0]          eff_class;
    logic [7:0]          cc;
    logic [8:0]          last_pos;
    logic                s_fire, is_box, is_done, upd, keep;
    logic [15:0]         new_score;
    logic [7:0]          new_class;
    logic [ANCHOR_W+13:0] anchor_ext;

    abd_pkg::box_cfg_t    cfg;
    abd_pkg::box_result_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= abd_pkg::RST_SCORE_THRESHOLD;
            class_count_reg     <= abd_pkg::RST_CLASS_COUNT;
            pad_left_reg        <= abd_pkg::RST_PAD_LEFT;
            pad_top_reg         <= abd_pkg::RST_PAD_TOP;
            inverse_gain_reg    <= abd_pkg::RST_INVERSE_GAIN;
            image_width_reg     <= abd_pkg::RST_IMAGE_WIDTH;
            image_height_reg    <= abd_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                abd_pkg::REG_SCORE_THRESHOLD: score_threshold_reg <= pwdata[15:0];
                abd_pkg::REG_CLASS_COUNT:     class_count_reg     <= pwdata[7:0];
                abd_pkg::REG_PAD_LEFT:        pad_left_reg        <= pwdata[15:0];
                abd_pkg::REG_PAD_TOP:         pad_top_reg         <= pwdata[15:0];
                abd_pkg::REG_INVERSE_GAIN:    inverse_gain_reg    <= pwdata[15:0];
                abd_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[12:0];
                abd_pkg::REG_IMAGE_HEIGHT:    image_height_reg    <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            abd_pkg::REG_SCORE_THRESHOLD: prdata = {16'd0, score_threshold_reg};
            abd_pkg::REG_CLASS_COUNT:     prdata = {24'd0, class_count_reg};
            abd_pkg::REG_PAD_LEFT:        prdata = {16'd0, pad_left_reg};
            abd_pkg::REG_PAD_TOP:         prdata = {16'd0, pad_top_reg};
            abd_pkg::REG_INVERSE_GAIN:    prdata = {16'd0, inverse_gain_reg};
            abd_pkg::REG_IMAGE_WIDTH:     prdata = {19'd0, image_width_reg};
            abd_pkg::REG_IMAGE_HEIGHT:    prdata = {19'd0, image_height_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.pad_left     = pad_left_reg;
        cfg.pad_top      = pad_top_reg;
        cfg.inverse_gain = inverse_gain_reg;
        if (image_width_reg == 13'd0)
            cfg.w_lim = 13'd1;
        else if (image_width_reg > abd_pkg::IMAGE_MAX)
            cfg.w_lim = abd_pkg::IMAGE_MAX;
        else
            cfg.w_lim = image_width_reg;
        if (image_height_reg == 13'd0)
            cfg.h_lim = 13'd1;
        else if (image_height_reg > abd_pkg::IMAGE_MAX)
            cfg.h_lim = abd_pkg::IMAGE_MAX;
        else
            cfg.h_lim = image_height_reg;
    end

    // running argmax and anchor framing
    always_comb
    begin
        if (class_count_reg == 8'd0)
            cc = 8'd1;
        else if (class_count_reg > CLASS_LIMIT)
            cc = CLASS_LIMIT;
        else
            cc = class_count_reg;
        last_pos = 9'd3 + {1'b0, cc};

        eff_pos    = s_tuser[0] ? 8'd0 : pos_reg;
        eff_anchor = s_tuser[0] ? '0 : anchor_reg;
        eff_score  = s_tuser[0] ? 16'd0 : best_score_reg;
        eff_class  = s_tuser[0] ? abd_pkg::CLASS_NONE : best_class_reg;

        is_box    = eff_pos < 8'd4;
        upd       = s_tdata > eff_score;
        new_score = upd ? s_tdata : eff_score;
        new_class = upd ? (eff_pos - 8'd4) : eff_class;
        is_done   = !is_box && ({1'b0, eff_pos} >= last_pos);
        keep      = is_done && (new_score >= score_threshold_reg);

        pos_next        = eff_pos + 8'd1;
        anchor_next     = eff_anchor;
        best_score_next = new_score;
        best_class_next = new_class;
        if (is_box)
        begin
            best_score_next = eff_score;
            best_class_next = eff_class;
        end
        else if (is_done)
        begin
            pos_next        = 8'd0;
            anchor_next     = (eff_anchor == ANCHOR_LAST) ? '0 : eff_anchor + ANCHOR_ONE;
            best_score_next = 16'd0;
            best_class_next = abd_pkg::CLASS_NONE;
        end
        anchor_ext = {14'd0, eff_anchor};
    end

    assign s_tready = !a_valid_reg || a_take;
    assign s_fire   = s_tvalid && s_tready;
    assign a_valid_next = (a_valid_reg && !a_take) || (s_fire && keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 8'd0;
            anchor_reg     <= '0;
            best_score_reg <= 16'd0;
            best_class_reg <= abd_pkg::CLASS_NONE;
            box_reg[0]     <= 16'd0;
            box_reg[1]     <= 16'd0;
            box_reg[2]     <= 16'd0;
            box_reg[3]     <= 16'd0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (s_fire)
            begin
                pos_reg        <= pos_next;
                anchor_reg     <= anchor_next;
                best_score_reg <= best_score_next;
                best_class_reg <= best_class_next;
                if (is_box)
                    box_reg[eff_pos[1:0]] <= s_tdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && keep)
        begin
            a_item_reg.cx                <= box_reg[0];
            a_item_reg.cy                <= box_reg[1];
            a_item_reg.w                 <= box_reg[2];
            a_item_reg.h                 <= box_reg[3];
            a_item_reg.meta.best_score   <= new_score;
            a_item_reg.meta.best_class   <= $signed(new_class);
            a_item_reg.meta.anchor_index <= anchor_ext[13:0];
        end
    end

    abd_box_math u_math
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (a_valid_reg),
        .in_ready  (a_take),
        .in_item   (a_item_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (res)
    );

    assign m_tdata = {res.meta.anchor_index, res.meta.best_class, res.meta.best_score,
                      res.box_height, res.box_width, res.box_top, res.box_left};

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> (pos_reg == 8'd1))
        else $error("frame start did not restart position");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[73:66] == abd_pkg::CLASS_NONE)) |-> (m_tdata[65:50] == 16'd0))
        else $error("no class but non-zero score");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (a_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// ----- rtl/abd_box_math.sv -----
// ----------------------------------------------------------------------------
// abd_box_math
// Letterbox removal, gain scaling, rounding and clamping of one kept anchor,
// in three registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module abd_box_math
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  abd_pkg::box_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  abd_pkg::box_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output abd_pkg::box_result_t out_item
);

    function automatic logic [11:0] edge_pixel(input logic signed [35:0] p,
                                               input logic [12:0] lim);
        logic [12:0] lm1;
        logic [35:0] top;
        logic [29:0] sum;
        lm1 = lim - 13'd1;
        top = {7'd0, lm1[11:0], 17'd0};
        sum = {1'b0, p[28:0]} + 30'h10000;
        if (p < 0)
        begin
            return 12'd0;
        end
        else if (p > $signed(top))
        begin
            return lm1[11:0];
        end
        else
        begin
            return sum[28:17];
        end
    endfunction

    function automatic logic [16:0] round_size(input logic [31:0] p);
        logic [32:0] sum;
        sum = {1'b0, p} + 33'h8000;
        return sum[32:16];
    endfunction

    function automatic logic [12:0] clamp_size(input logic [16:0] r,
                                               input logic [12:0] lim,
                                               input logic [11:0] origin);
        logic [12:0] room;
        room = lim - {1'b0, origin};
        if ({4'd0, room} < r)
        begin
            return room;
        end
        else
        begin
            return r[12:0];
        end
    endfunction

    logic                     b_valid_reg, b_valid_next;
    logic                     c_valid_reg, c_valid_next;
    logic                     o_valid_reg, o_valid_next;
    logic                     b_ready, c_ready, o_ready;
    logic                     b_load, c_load, o_load;

    logic signed [18:0]       dx, dy;
    logic signed [35:0]       px_reg, py_reg;
    logic [31:0]              pw_reg, ph_reg;
    abd_pkg::meta_t           b_meta_reg;

    logic [11:0]              xl_reg, yt_reg;
    logic [16:0]              rw_reg, rh_reg;
    abd_pkg::meta_t           c_meta_reg;

    abd_pkg::box_result_t     o_item_reg;

    assign o_ready  = !o_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || o_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    assign b_load = in_valid && b_ready;
    assign c_load = b_valid_reg && c_ready;
    assign o_load = c_valid_reg && o_ready;

    assign b_valid_next = b_load || (b_valid_reg && !c_ready);
    assign c_valid_next = c_load || (c_valid_reg && !o_ready);
    assign o_valid_next = o_load || (o_valid_reg && !out_ready);

    assign dx = ($signed({3'd0, in_item.cx}) - $signed({3'd0, cfg.pad_left})) * 19'sd2
                - $signed({3'd0, in_item.w});
    assign dy = ($signed({3'd0, in_item.cy}) - $signed({3'd0, cfg.pad_top})) * 19'sd2
                - $signed({3'd0, in_item.h});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            px_reg     <= dx * $signed({1'b0, cfg.inverse_gain});
            py_reg     <= dy * $signed({1'b0, cfg.inverse_gain});
            pw_reg     <= in_item.w * cfg.inverse_gain;
            ph_reg     <= in_item.h * cfg.inverse_gain;
            b_meta_reg <= in_item.meta;
        end
        if (c_load)
        begin
            xl_reg     <= edge_pixel(px_reg, cfg.w_lim);
            yt_reg     <= edge_pixel(py_reg, cfg.h_lim);
            rw_reg     <= round_size(pw_reg);
            rh_reg     <= round_size(ph_reg);
            c_meta_reg <= b_meta_reg;
        end
        if (o_load)
        begin
            o_item_reg.box_left   <= xl_reg;
            o_item_reg.box_top    <= yt_reg;
            o_item_reg.box_width  <= clamp_size(rw_reg, cfg.w_lim, xl_reg);
            o_item_reg.box_height <= clamp_size(rh_reg, cfg.h_lim, yt_reg);
            o_item_reg.meta       <= c_meta_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

    a_left_inside: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> ({1'b0, o_item_reg.box_left} < cfg.w_lim))
        else $error("box_left outside image");

    a_width_inside: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> ({2'b0, o_item_reg.box_left} + {1'b0, o_item_reg.box_width}
                         <= {1'b0, cfg.w_lim}))
        else $error("box runs past right edge");

    a_height_inside: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> ({2'b0, o_item_reg.box_top} + {1'b0, o_item_reg.box_height}
                         <= {1'b0, cfg.h_lim}))
        else $error("box runs past bottom edge");

endmodule

// ----- tb/box_decode_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_decode_checker
// Watches the feature, box and register channels of the anchor box decoder.
// Mirrors the register file from observed writes, runs its own argmax and
// letterbox arithmetic on every accepted feature word, queues the boxes it
// predicts and compares each box leaving the block, field by field, against
// the oldest queued one. Hands the mismatch count and queue depth upwards.
// ----------------------------------------------------------------------------
module box_decode_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // feature_value
    input  logic [0:0]  s_tuser,   // frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    // box_left, box_top, box_width, box_height, best_score, best_class,
    // anchor_index
    input  logic [87:0] m_tdata,
    output int          errors,
    output int          pending,
    output int          words_seen,
    output int          boxes_seen
);

    typedef struct packed {
        logic [11:0]       left;
        logic [11:0]       top;
        logic [12:0]       width;
        logic [12:0]       height;
        logic [15:0]       score;
        logic signed [7:0] cls;
        logic [13:0]       index;
    } box_rec_t;

    box_rec_t expected_boxes[$];

    logic [15:0] cfg_threshold;
    logic [7:0]  cfg_classes;
    logic [15:0] cfg_pad_left;
    logic [15:0] cfg_pad_top;
    logic [15:0] cfg_gain;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;

    logic [7:0]  position;
    logic [13:0] anchor_no;
    logic [15:0] box_val [4];
    logic [15:0] top_score;
    logic [7:0]  top_class;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > abd_pkg::IMAGE_MAX)
            return abd_pkg::IMAGE_MAX;
        return v;
    endfunction

    function automatic logic [11:0] corner_px(input logic [15:0] c, input logic [15:0] s,
                                              input logic [15:0] pad, input logic [12:0] lim);
        longint d;
        longint p;
        longint ceiling;
        d = 2 * (longint'(c) - longint'(pad)) - longint'(s);
        p = d * longint'(cfg_gain);
        ceiling = (longint'(lim) - 1) <<< 17;
        if (p < 0)
            return 12'd0;
        if (p > ceiling)
            return 12'(longint'(lim) - 1);
        return 12'((p + 65536) >>> 17);
    endfunction

    function automatic logic [12:0] extent_px(input logic [15:0] s, input logic [12:0] room);
        longint p;
        longint r;
        p = longint'(s) * longint'(cfg_gain);
        r = (p + 32768) >>> 16;
        if (r > longint'(room))
            return room;
        return 13'(r);
    endfunction

    task automatic take_feature(input logic [15:0] v, input logic fs);
        int unsigned cc;
        int unsigned last;
        logic [12:0] wl;
        logic [12:0] hl;
        box_rec_t    r;
        cc = {24'd0, cfg_classes};
        if (cc < 1)
            cc = 1;
        if (cc > abd_pkg::MAX_CLASSES_DEF)
            cc = abd_pkg::MAX_CLASSES_DEF;
        last = 3 + cc;
        if (fs)
        begin
            position  = 8'd0;
            anchor_no = 14'd0;
            top_score = 16'd0;
            top_class = abd_pkg::CLASS_NONE;
        end
        if (position < 4)
        begin
            box_val[position[1:0]] = v;
            position = position + 8'd1;
        end
        else
        begin
            if (v > top_score)
            begin
                top_score = v;
                top_class = position - 8'd4;
            end
            if (position >= last)
            begin
                if (top_score >= cfg_threshold)
                begin
                    wl = clamp_dim(cfg_width);
                    hl = clamp_dim(cfg_height);
                    r.left   = corner_px(box_val[0], box_val[2], cfg_pad_left, wl);
                    r.top    = corner_px(box_val[1], box_val[3], cfg_pad_top, hl);
                    r.width  = extent_px(box_val[2], wl - {1'b0, r.left});
                    r.height = extent_px(box_val[3], hl - {1'b0, r.top});
                    r.score  = top_score;
                    r.cls    = top_class;
                    r.index  = anchor_no;
                    expected_boxes = {expected_boxes, r};
                end
                anchor_no = anchor_no + 14'd1;
                position  = 8'd0;
                top_score = 16'd0;
                top_class = abd_pkg::CLASS_NONE;
            end
            else
            begin
                position = position + 8'd1;
            end
        end
    endtask

    task automatic load_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            abd_pkg::REG_SCORE_THRESHOLD: cfg_threshold = value[15:0];
            abd_pkg::REG_CLASS_COUNT:     cfg_classes   = value[7:0];
            abd_pkg::REG_PAD_LEFT:        cfg_pad_left  = value[15:0];
            abd_pkg::REG_PAD_TOP:         cfg_pad_top   = value[15:0];
            abd_pkg::REG_INVERSE_GAIN:    cfg_gain      = value[15:0];
            abd_pkg::REG_IMAGE_WIDTH:     cfg_width     = value[12:0];
            abd_pkg::REG_IMAGE_HEIGHT:    cfg_height    = value[12:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors = errors + 1;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want,
                     got);
        end
    endtask

    task automatic check_box(input logic [87:0] word);
        box_rec_t want;
        box_rec_t got;
        got.left   = word[11:0];
        got.top    = word[23:12];
        got.width  = word[36:24];
        got.height = word[49:37];
        got.score  = word[65:50];
        got.cls    = word[73:66];
        got.index  = word[87:74];
        boxes_seen = boxes_seen + 1;
        if (expected_boxes.size() == 0)
        begin
            errors = errors + 1;
            $display("%0t ns: box with none expected, expected nothing, actual %h", $time,
                     word);
        end
        else
        begin
            want = expected_boxes.pop_front();
            compare_field("box_left", longint'(want.left), longint'(got.left));
            compare_field("box_top", longint'(want.top), longint'(got.top));
            compare_field("box_width", longint'(want.width), longint'(got.width));
            compare_field("box_height", longint'(want.height), longint'(got.height));
            compare_field("best_score", longint'(want.score), longint'(got.score));
            compare_field("best_class", longint'(want.cls), longint'(got.cls));
            compare_field("anchor_index", longint'(want.index), longint'(got.index));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_threshold = abd_pkg::RST_SCORE_THRESHOLD;
            cfg_classes   = abd_pkg::RST_CLASS_COUNT;
            cfg_pad_left  = abd_pkg::RST_PAD_LEFT;
            cfg_pad_top   = abd_pkg::RST_PAD_TOP;
            cfg_gain      = abd_pkg::RST_INVERSE_GAIN;
            cfg_width     = abd_pkg::RST_IMAGE_WIDTH;
            cfg_height    = abd_pkg::RST_IMAGE_HEIGHT;
            position      = 8'd0;
            anchor_no     = 14'd0;
            box_val[0]    = 16'd0;
            box_val[1]    = 16'd0;
            box_val[2]    = 16'd0;
            box_val[3]    = 16'd0;
            top_score     = 16'd0;
            top_class     = abd_pkg::CLASS_NONE;
            errors        = 0;
            words_seen    = 0;
            boxes_seen    = 0;
            expected_boxes.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_box(m_tdata);
            if (s_tvalid && s_tready)
            begin
                take_feature(s_tdata, s_tuser[0]);
                words_seen = words_seen + 1;
            end
            if (psel && penable && pwrite && pready)
                load_register(paddr[4:2], pwdata);
            pending <= expected_boxes.size();
        end
    end

endmodule

// ----- tb/anchor_box_decode_argmax_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_box_decode_argmax_tb
// Drives feature words and register writes into the anchor box decoder and
// lets the checker beside it predict and compare every box. A short directed
// run covers zero and full-scale values, ties and a restart mid-anchor; then
// phases of random anchors run under different register settings and idle
// and stall mixes, including a class count lowered mid-anchor and zero gain.
// ----------------------------------------------------------------------------
module anchor_box_decode_argmax_tb;

    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // feature_value
    logic [0:0]  s_tuser = 1'b0;    // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // box_left, box_top, box_width, box_height, best_score, best_class,
    // anchor_index
    logic [87:0] m_tdata;

    int errors;
    int pending;
    int words_seen;
    int boxes_seen;

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles = 0;
    int          sent_words = 0;
    int          settings_used = 0;
    logic [15:0] cur_threshold = abd_pkg::RST_SCORE_THRESHOLD;
    int          cur_classes = int'(abd_pkg::RST_CLASS_COUNT);
    logic [15:0] last_score = 16'd0;

    anchor_box_decode_argmax uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    box_decode_checker box_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .words_seen (words_seen),
        .boxes_seen (boxes_seen)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int thr, input int classes, input int pl, input int pt,
                              input int gain, input int w, input int h);
        write_reg(abd_pkg::REG_SCORE_THRESHOLD, thr);
        write_reg(abd_pkg::REG_CLASS_COUNT, classes);
        write_reg(abd_pkg::REG_PAD_LEFT, pl);
        write_reg(abd_pkg::REG_PAD_TOP, pt);
        write_reg(abd_pkg::REG_INVERSE_GAIN, gain);
        write_reg(abd_pkg::REG_IMAGE_WIDTH, w);
        write_reg(abd_pkg::REG_IMAGE_HEIGHT, h);
        cur_threshold = 16'(thr);
        cur_classes   = (classes < 1) ? 1
                      : (classes > abd_pkg::MAX_CLASSES_DEF) ? abd_pkg::MAX_CLASSES_DEF
                                                             : classes;
        settings_used = settings_used + 1;
    endtask

    task automatic send_word(input logic [15:0] v, input logic fs);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words = sent_words + 1;
    endtask

    // drain: hold off the sender until every box is out and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [15:0] score_word();
        logic [15:0] s;
        case ($urandom_range(7))
            0: s = 16'd0;
            1: s = 16'hFFFF;
            2: s = cur_threshold;
            3: s = cur_threshold - 16'd1;
            4: s = last_score;
            default: s = 16'($urandom);
        endcase
        last_score = s;
        return s;
    endfunction

    task automatic send_anchor(input int scores, input bit raw, input bit noisy,
                               input bit restart);
        logic [15:0] v;
        logic        fs;
        int          i;
        for (i = 0; i < 4 + scores; i++)
        begin
            if (i >= 4)
                v = score_word();
            else if (raw)
                v = 16'($urandom);
            else if (i < 2)
                v = 16'($urandom_range(0, 16000));
            else
                v = 16'($urandom_range(0, 6000));
            fs = (i == 0) && (restart || (noisy && $urandom_range(7) == 0));
            if (noisy && i > 0 && $urandom_range(59) == 0)
                fs = 1'b1;
            send_word(v, fs);
        end
    endtask

    initial
    begin
        int phase;
        int first_word;
        int i;
        int scores;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(0, 2, 0, 0, 4096, 640, 640);
        send_word(16'd0, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        repeat (6)
            send_word(16'hFFFF, 1'b0);
        send_word(16'd5120, 1'b0);
        send_word(16'd3840, 1'b0);
        send_word(16'd1600, 1'b0);
        send_word(16'd800, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd200, 1'b0);
        send_word(16'd4000, 1'b1);
        send_word(16'd4000, 1'b0);
        send_word(16'd800, 1'b0);
        send_word(16'd800, 1'b0);
        send_word(16'h4000, 1'b0);
        send_word(16'h3FFF, 1'b0);

        for (phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 52;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 52;
                end
                default:
                begin
                    sender_idle_pct    = 23;
                    receiver_stall_pct = 23;
                end
            endcase
            case (phase)
                0: set_config(0, 1, 0, 0, 4096, 640, 480);
                1: set_config(32768, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(1, 65535), 4096, 1);
                2: set_config(65535, 0, 65535, 0, 0, 0, 8191);
                3: set_config(0, 255, 0, 65535, 65535, 4096, 4096);
                4: set_config(1, 128, 320, 160, 6827, 1920, 1080);
                5:
                begin
                    // lower the class count with the anchor four scores into its six
                    set_config(256, 6, 0, 0, 4096, 640, 640);
                    for (i = 0; i < 8; i++)
                        send_word((i < 4) ? 16'($urandom_range(0, 9000)) : score_word(),
                                  i == 0);
                    wait_idle();
                    write_reg(abd_pkg::REG_CLASS_COUNT, 2);
                    cur_classes = 2;
                    send_word(score_word(), 1'b0);
                end
                default:
                    set_config($urandom_range(0, 65535), $urandom_range(1, 8),
                               $urandom_range(1) ? $urandom_range(0, 400)
                                                 : $urandom_range(0, 65535),
                               $urandom_range(1) ? $urandom_range(0, 400)
                                                 : $urandom_range(0, 65535),
                               $urandom_range(1, 65535), $urandom_range(1, 4096),
                               $urandom_range(1, 4096));
            endcase
            first_word = sent_words;
            do
            begin
                scores = ($urandom_range(9) == 0) ? $urandom_range(0, cur_classes + 3)
                                                  : cur_classes;
                send_anchor(scores, $urandom_range(3) == 0, 1'b1, 1'b0);
            end
            while (sent_words - first_word < PHASE_WORDS);
        end

        wait_idle();
        $display("Summary: %0d feature words and %0d boxes checked over %0d register settings",
                 words_seen, boxes_seen, settings_used);
        $display("Covered: register extremes, zero gain, restarts, class count cut, idle and "
                 , "stall mixes");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/abd_pkg.sv
rtl/abd_box_math.sv
rtl/anchor_box_decode_argmax.sv
tb/box_decode_checker.sv
tb/anchor_box_decode_argmax_tb.sv
